### rtl/sfcd_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and crc helper for the sync frame deframer
// no dependencies

package sfcd_pkg;

    localparam int unsigned SYNC_W   = 24;
    localparam int unsigned TYPE_W   = 16;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned CRC_W    = 32;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = SYNC_W;

    localparam logic [CRC_W-1:0]  CRC_POLY          = 32'hEDB8_8320;
    localparam logic [SYNC_W-1:0] SYNC_PATTERN_RST  = 24'hFA3C5F;
    localparam logic [TYPE_W-1:0] WANTED_TYPE_RST   = 16'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_PATTERN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WANTED_TYPE  = 2'd1;

    localparam logic KIND_PAYLOAD   = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    typedef enum logic [5:0] {
        PH_SYNC0   = 6'b000001,
        PH_SYNC1   = 6'b000010,
        PH_SYNC2   = 6'b000100,
        PH_HEADER  = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_CRC     = 6'b100000
    } t_phase;

    // reflected crc-32 update by one byte
    function automatic logic [CRC_W-1:0] crc32_byte(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = {24'd0, crc[7:0] ^ b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return {8'd0, crc[31:8]} ^ c;
    endfunction

endpackage

### rtl/sfcd_in_if.sv
`timescale 1ns / 1ps
// byte input channel of the sync frame deframer
// depends on sfcd_pkg

interface sfcd_in_if;
    logic                       valid;
    logic                       ready;
    logic [sfcd_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

### rtl/sfcd_out_if.sv
`timescale 1ns / 1ps
// result channel of the sync frame deframer
// depends on sfcd_pkg

interface sfcd_out_if;
    logic                        valid;
    logic                        ready;
    logic                        item_kind;
    logic [sfcd_pkg::BYTE_W-1:0] payload_byte;
    logic [sfcd_pkg::LEN_W-1:0]  byte_offset;
    logic [sfcd_pkg::TYPE_W-1:0] message_type;
    logic [sfcd_pkg::LEN_W-1:0]  message_length;
    logic                        crc_ok;
    logic                        type_match;

    modport source (output valid, output item_kind, output payload_byte, output byte_offset,
                    output message_type, output message_length, output crc_ok,
                    output type_match, input ready);
    modport sink   (input valid, input item_kind, input payload_byte, input byte_offset,
                    input message_type, input message_length, input crc_ok,
                    input type_match, output ready);
endinterface

### rtl/sync_frame_crc32_deframer_core.sv
`timescale 1ns / 1ps
// sync word deframer with crc-32 check, top level
// depends on sfcd_pkg, sfcd_in_if, sfcd_out_if
// an input transfer's result is in the output register in the next cycle
// one byte per cycle while i_in.ready is high; the output refills in the cycle it drains
// reset: synchronous active low, returns to sync hunt and loads default sync and type

module sync_frame_crc32_deframer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sfcd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sfcd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    sfcd_in_if.sink                           i_in,
    sfcd_out_if.source                        o_out
);
    import sfcd_pkg::*;

    logic [SYNC_W-1:0] r_sync_pattern, n_sync_pattern;
    logic [TYPE_W-1:0] r_wanted_type, n_wanted_type;

    t_phase            r_phase, n_phase;
    logic [CRC_W-1:0]  r_running_crc, n_running_crc;
    logic [LEN_W-1:0]  r_byte_count, n_byte_count;
    logic [TYPE_W-1:0] r_frame_type, n_frame_type;
    logic [LEN_W-1:0]  r_frame_length, n_frame_length;
    logic [CRC_W-1:0]  r_received_crc, n_received_crc;

    logic              r_out_valid, n_out_valid;
    logic              r_item_kind, n_item_kind;
    logic [BYTE_W-1:0] r_payload_byte, n_payload_byte;
    logic [LEN_W-1:0]  r_byte_offset, n_byte_offset;
    logic [TYPE_W-1:0] r_message_type, n_message_type;
    logic [LEN_W-1:0]  r_message_length, n_message_length;
    logic              r_crc_ok, n_crc_ok;
    logic              r_type_match, n_type_match;

    logic              w_accept;
    logic              w_emit;
    logic              w_match;
    logic [BYTE_W-1:0] w_b;
    logic [BYTE_W-1:0] w_want;
    logic [CRC_W-1:0]  w_crc_upd;
    logic [CRC_W-1:0]  w_rx_crc;
    logic [LEN_W:0]    w_next_off;
    logic [LEN_W-1:0]  w_hdr_len;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_b        = i_in.data_byte;
    assign w_match    = (r_frame_type == r_wanted_type);
    assign w_crc_upd  = crc32_byte(r_running_crc, w_b);
    assign w_next_off = {1'b0, r_byte_count} + 17'd1;
    assign w_hdr_len  = {w_b, r_frame_length[7:0]};

    always_comb begin
        case (r_phase)
            PH_SYNC0: w_want = r_sync_pattern[23:16];
            PH_SYNC1: w_want = r_sync_pattern[15:8];
            default:  w_want = r_sync_pattern[7:0];
        endcase
        case (r_byte_count[1:0])
            2'd0:    w_rx_crc = r_received_crc | {24'd0, w_b};
            2'd1:    w_rx_crc = r_received_crc | {16'd0, w_b, 8'd0};
            2'd2:    w_rx_crc = r_received_crc | {8'd0, w_b, 16'd0};
            default: w_rx_crc = r_received_crc | {w_b, 24'd0};
        endcase
    end

    // configuration writes
    always_comb begin
        n_sync_pattern = r_sync_pattern;
        n_wanted_type  = r_wanted_type;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SYNC_PATTERN: n_sync_pattern = i_cfg_data[SYNC_W-1:0];
                CFG_WANTED_TYPE:  n_wanted_type  = i_cfg_data[TYPE_W-1:0];
                default: ;
            endcase
        end
    end

    // frame state machine and result capture
    always_comb begin
        n_phase          = r_phase;
        n_running_crc    = r_running_crc;
        n_byte_count     = r_byte_count;
        n_frame_type     = r_frame_type;
        n_frame_length   = r_frame_length;
        n_received_crc   = r_received_crc;
        w_emit           = 1'b0;
        n_item_kind      = r_item_kind;
        n_payload_byte   = r_payload_byte;
        n_byte_offset    = r_byte_offset;
        n_message_type   = r_message_type;
        n_message_length = r_message_length;
        n_crc_ok         = r_crc_ok;
        n_type_match     = r_type_match;

        if (w_accept) begin
            unique case (r_phase)
                PH_SYNC0, PH_SYNC1, PH_SYNC2: begin
                    if (w_b != w_want) begin
                        n_phase       = PH_SYNC0;
                        n_running_crc = '0;
                        n_byte_count  = '0;
                    end else begin
                        n_running_crc = (r_phase == PH_SYNC0) ? crc32_byte('0, w_b) : w_crc_upd;
                        if (r_phase == PH_SYNC0) begin
                            n_phase = PH_SYNC1;
                        end else if (r_phase == PH_SYNC1) begin
                            n_phase = PH_SYNC2;
                        end else begin
                            n_phase        = PH_HEADER;
                            n_byte_count   = '0;
                            n_frame_type   = '0;
                            n_frame_length = '0;
                        end
                    end
                end
                PH_HEADER: begin
                    n_running_crc = w_crc_upd;
                    case (r_byte_count[1:0])
                        2'd0:    n_frame_type   = {8'd0, w_b};
                        2'd1:    n_frame_type   = {w_b, r_frame_type[7:0]};
                        2'd2:    n_frame_length = {8'd0, w_b};
                        default: n_frame_length = w_hdr_len;
                    endcase
                    if (r_byte_count[1:0] == 2'd3) begin
                        n_byte_count   = '0;
                        n_received_crc = '0;
                        n_phase        = (w_hdr_len == '0) ? PH_CRC : PH_PAYLOAD;
                    end else begin
                        n_byte_count = w_next_off[LEN_W-1:0];
                    end
                end
                PH_PAYLOAD: begin
                    n_running_crc = w_crc_upd;
                    if (w_next_off >= {1'b0, r_frame_length}) begin
                        n_phase        = PH_CRC;
                        n_byte_count   = '0;
                        n_received_crc = '0;
                    end else begin
                        n_byte_count = w_next_off[LEN_W-1:0];
                    end
                    if (w_match) begin
                        w_emit           = 1'b1;
                        n_item_kind      = KIND_PAYLOAD;
                        n_payload_byte   = w_b;
                        n_byte_offset    = r_byte_count;
                        n_message_type   = r_frame_type;
                        n_message_length = r_frame_length;
                        n_crc_ok         = 1'b0;
                        n_type_match     = 1'b1;
                    end
                end
                PH_CRC: begin
                    n_received_crc = w_rx_crc;
                    if (r_byte_count[1:0] != 2'd3) begin
                        n_byte_count = w_next_off[LEN_W-1:0];
                    end else begin
                        w_emit           = 1'b1;
                        n_item_kind      = KIND_FRAME_END;
                        n_payload_byte   = '0;
                        n_byte_offset    = '0;
                        n_message_type   = r_frame_type;
                        n_message_length = r_frame_length;
                        n_crc_ok         = (w_rx_crc == r_running_crc);
                        n_type_match     = w_match;
                        n_phase          = PH_SYNC0;
                        n_running_crc    = '0;
                        n_byte_count     = '0;
                    end
                end
                default: begin
                    n_phase       = PH_SYNC0;
                    n_running_crc = '0;
                    n_byte_count  = '0;
                end
            endcase
        end

        // output register holds until its transfer, refills on a new result
        n_out_valid = (r_out_valid && !o_out.ready) || w_emit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_pattern <= SYNC_PATTERN_RST;
            r_wanted_type  <= WANTED_TYPE_RST;
            r_phase        <= PH_SYNC0;
            r_running_crc  <= '0;
            r_byte_count   <= '0;
            r_frame_type   <= '0;
            r_frame_length <= '0;
            r_received_crc <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_sync_pattern <= n_sync_pattern;
            r_wanted_type  <= n_wanted_type;
            r_phase        <= n_phase;
            r_running_crc  <= n_running_crc;
            r_byte_count   <= n_byte_count;
            r_frame_type   <= n_frame_type;
            r_frame_length <= n_frame_length;
            r_received_crc <= n_received_crc;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item_kind      <= n_item_kind;
        r_payload_byte   <= n_payload_byte;
        r_byte_offset    <= n_byte_offset;
        r_message_type   <= n_message_type;
        r_message_length <= n_message_length;
        r_crc_ok         <= n_crc_ok;
        r_type_match     <= n_type_match;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.item_kind      = r_item_kind;
    assign o_out.payload_byte   = r_payload_byte;
    assign o_out.byte_offset    = r_byte_offset;
    assign o_out.message_type   = r_message_type;
    assign o_out.message_length = r_message_length;
    assign o_out.crc_ok         = r_crc_ok;
    assign o_out.type_match     = r_type_match;

endmodule
